// ----- rtl/dq_pkg.sv -----
// Package for the double-ended queue: depth, derived widths, operation and status codes.
// Used by double_ended_queue; depends on nothing else.
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] EMPTY_MARK = '1;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } dq_action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } dq_status_e;

endpackage

// ----- rtl/double_ended_queue.sv -----
// A result is registered in the cycle after its word is accepted; a pop that leaves two or
// more entries first passes a read state, as the new end entry comes from the slot memory.
// Throughput: one word per cycle while the output is taken, except those pops, which
// hold off input in the read state while the registered read of the slot memory completes.
// Reset clears the head index, entry count, control state and output valid; the slot
// memory is not cleared, as every slot is written before it is read.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               action_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] popped_value_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] back_value_o,
  output logic [CNT_W-1:0]         item_count_o
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               status_q, status_d;
  logic signed [DATA_W-1:0] popped_q, popped_d;
  logic signed [DATA_W-1:0] front_q, front_d;
  logic signed [DATA_W-1:0] back_q, back_d;
  logic                     rd_front_q, rd_front_d;

  logic             accept;
  logic             empty;
  logic             full;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             needs_read;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q == DEPTH_CNT);
  assign needs_read = (count_q > CNT_W'(2));

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    popped_d    = popped_q;
    front_d     = front_q;
    back_d      = back_q;
    rd_front_d  = rd_front_q;
    mem_we      = 1'b0;
    wr_addr     = ring_add(head_q, count_q);
    rd_addr     = ring_add(head_q, CNT_W'(1));

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (state_q == ST_READ) begin
      state_d     = ST_IDLE;
      out_valid_d = 1'b1;
      if (rd_front_q) begin
        front_d = rd_data_q;
      end else begin
        back_d = rd_data_q;
      end
    end else if (accept) begin
      out_valid_d = 1'b1;
      popped_d    = '0;
      status_d    = STAT_OK;
      unique case (dq_action_e'(action_i))
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (full) begin
            status_d = STAT_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
            if (dq_action_e'(action_i) == ACT_PUSH_FRONT) begin
              head_d  = ring_add(head_q, DEPTH_CNT - CNT_W'(1));
              wr_addr = head_d;
              front_d = value_i;
              back_d  = empty ? value_i : back_q;
            end else begin
              back_d  = value_i;
              front_d = empty ? value_i : front_q;
            end
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            status_d = STAT_UNDERFLOW;
          end else begin
            popped_d   = front_q;
            head_d     = ring_add(head_q, CNT_W'(1));
            count_d    = count_q - CNT_W'(1);
            rd_front_d = 1'b1;
            if (count_q == CNT_W'(1)) begin
              front_d = EMPTY_MARK;
              back_d  = EMPTY_MARK;
            end else if (count_q == CNT_W'(2)) begin
              front_d = back_q;
            end else begin
              state_d     = ST_READ;
              out_valid_d = 1'b0;
            end
          end
        end
        ACT_POP_BACK: begin
          rd_addr = ring_add(head_q, count_q - CNT_W'(2));
          if (empty) begin
            status_d = STAT_UNDERFLOW;
          end else begin
            popped_d   = back_q;
            count_d    = count_q - CNT_W'(1);
            rd_front_d = 1'b0;
            if (count_q == CNT_W'(1)) begin
              front_d = EMPTY_MARK;
              back_d  = EMPTY_MARK;
            end else if (count_q == CNT_W'(2)) begin
              back_d = front_q;
            end else begin
              state_d     = ST_READ;
              out_valid_d = 1'b0;
            end
          end
        end
        default: begin
          status_d = STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STAT_OK;
      popped_q    <= '0;
      front_q     <= EMPTY_MARK;
      back_q      <= EMPTY_MARK;
      rd_front_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      popped_q    <= popped_d;
      front_q     <= front_d;
      back_q      <= back_d;
      rd_front_q  <= rd_front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign front_value_o  = front_q;
  assign back_value_o   = back_q;
  assign item_count_o   = count_q;

  // The entry count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DEPTH_CNT)
    else $error("entry count exceeds depth");

  // A pop that leaves two or more entries enters the read state, with no result valid, to wait for the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i[1] && needs_read |=> state_q == ST_READ && !out_valid_q)
    else $error("deep pop did not wait for the slot read");

  // The read state always ends with a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_IDLE && out_valid_q)
    else $error("read cycle did not produce a result");

  // A successful push adds exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !action_i[1] && !full |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not add one entry");

  // Underflow is reported only on an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == STAT_UNDERFLOW |-> count_q == '0)
    else $error("underflow reported on a non-empty queue");

endmodule
